// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/frt_pkg.sv -----
package frt_pkg;

    localparam int CODE_REGS  = 6;
    localparam int MAX_SLOTS  = 6;
    localparam int CODE_W     = 8;
    localparam int CODE_IDX_W = $clog2(CODE_REGS);
    localparam int CMD_W      = 2;
    localparam int POS_W      = 3;
    localparam int TOTAL_W    = 3;
    localparam int DET_W      = 16;
    localparam int REV_W      = 16;
    localparam int EVT_W      = 32;
    localparam int OCC_W      = 16;
    localparam int IN_W       = 80;
    localparam int OUT_W      = 160;

    localparam logic [CMD_W-1:0] CMD_RAISE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CODE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_POS = 2'd3;

    localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

    typedef logic [CODE_REGS-1:0][CODE_W-1:0] t_codes;

    typedef struct packed {
        logic [2:0]        pad;
        logic [POS_W-1:0]  act_pos;
        logic [EVT_W-1:0]  evt_id;
        logic [REV_W-1:0]  config_revision;
        logic [DET_W-1:0]  detail;
        logic [CODE_W-1:0] fault_code;
        logic [CMD_W-1:0]  cmd;
    } t_item;

    typedef struct packed {
        logic              active;
        logic [DET_W-1:0]  first_det;
        logic [REV_W-1:0]  first_revision;
        logic [EVT_W-1:0]  first_event;
        logic [DET_W-1:0]  last_det;
        logic [REV_W-1:0]  last_revision;
        logic [EVT_W-1:0]  last_event;
        logic [OCC_W-1:0]  occurrences;
    } t_record;

    typedef struct packed {
        logic [2:0]         pad;
        logic [OCC_W-1:0]   rec_occurrences;
        logic [EVT_W-1:0]   rec_last_event;
        logic [REV_W-1:0]   rec_last_revision;
        logic [DET_W-1:0]   rec_last_det;
        logic [EVT_W-1:0]   rec_first_event;
        logic [REV_W-1:0]   rec_first_revision;
        logic [DET_W-1:0]   rec_first_det;
        logic               rec_active;
        logic [CODE_W-1:0]  rec_code;
        logic [TOTAL_W-1:0] active_total;
        logic               ok;
    } t_result;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

    typedef struct packed {
        logic raise;
        logic clear;
    } t_store_wr;

endpackage

// ----- hdl/fault_record_table.sv -----
// Fault record table.
// Input stream s_axis carries one command per transaction (raise, clear, read by
// code, read by active position); m_axis returns exactly one result per command.
// Slot codes are set through the write port i_cfg_we / i_cfg_idx / i_cfg_data,
// one register per edge with i_cfg_we high; they are to be written only while
// no command is in flight, which the block itself does not enforce.
// A command is handled by one comparator stepped over the slots, one slot per
// cycle, until the lowest match (or the last slot), then an update state writes
// the record (raise or clear that matched) and an output state loads the result
// once the output register is free.
// s_axis_tready is high only while no command is in flight, so a new command
// is taken at the earliest in the cycle after the previous result is loaded.
// When the receiver stalls, the finished result waits in the output register;
// the block still accepts the next command and scans it, and only holds that
// command's result until the register is free.
// Synchronous reset clears all records, the active count and the result valid,
// and returns slot code registers to 0..5.
module fault_record_table #(
    parameter int RECORD_SLOTS = frt_pkg::MAX_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cmd, fault_code, detail, config_revision, event id, active position, zero fill
    input  logic [frt_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // ok, active_total, rec_code, rec_active, rec_first_det,
    // rec_first_revision, rec_first_event, rec_last_det, rec_last_revision,
    // rec_last_event, rec_occurrences, zero fill
    output logic [frt_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [frt_pkg::CODE_IDX_W-1:0] i_cfg_idx,
    input  logic [frt_pkg::CODE_W-1:0]    i_cfg_data
);
    import frt_pkg::*;

    localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         r_state, n_state;
    t_item              r_item;
    t_codes             r_codes;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_m_valid, n_m_valid;
    t_result            r_m_data, n_m_data;

    logic               w_accept;
    logic               w_start;
    t_scan_sts          w_sts;
    logic               w_found;
    logic [IDX_W-1:0]   w_slot;
    t_store_wr          w_wr;
    t_record            w_rec;
    logic [RECORD_SLOTS-1:0] w_active;
    logic               w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    frt_scan #(
        .RECORD_SLOTS(RECORD_SLOTS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_by_pos (r_item.cmd == CMD_READ_POS),
        .i_code   (r_item.fault_code),
        .i_pos    (r_item.act_pos),
        .i_codes  (r_codes),
        .i_active (w_active),
        .o_sts    (w_sts),
        .o_slot   (w_slot)
    );

    frt_store #(
        .RECORD_SLOTS(RECORD_SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_slot     (w_slot),
        .i_detail   (r_item.detail),
        .i_revision (r_item.config_revision),
        .i_event    (r_item.evt_id),
        .o_rec      (w_rec),
        .o_active   (w_active)
    );

    assign w_found = w_sts.found;

    always_comb begin
        w_wr.raise = (r_state == ST_UPD) && (r_item.cmd == CMD_RAISE);
        w_wr.clear = (r_state == ST_UPD) && (r_item.cmd == CMD_CLEAR);
    end

    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_sts.done) begin
                    if (w_sts.found && ((r_item.cmd == CMD_RAISE) ||
                                        (r_item.cmd == CMD_CLEAR))) begin
                        n_state = ST_UPD;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_UPD: begin
                if (w_wr.raise && !w_rec.active) begin
                    n_total = r_total + 1'b1;
                end else if (w_wr.clear && w_rec.active) begin
                    n_total = r_total - 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_m_valid             = 1'b1;
                    n_m_data              = '0;
                    n_m_data.ok           = w_found;
                    n_m_data.active_total = r_total;
                    if (w_found) begin
                        n_m_data.rec_code           = r_codes[CODE_IDX_W'(w_slot)];
                        n_m_data.rec_active         = w_rec.active;
                        n_m_data.rec_first_det      = w_rec.first_det;
                        n_m_data.rec_first_revision = w_rec.first_revision;
                        n_m_data.rec_first_event    = w_rec.first_event;
                        n_m_data.rec_last_det       = w_rec.last_det;
                        n_m_data.rec_last_revision  = w_rec.last_revision;
                        n_m_data.rec_last_event     = w_rec.last_event;
                        n_m_data.rec_occurrences    = w_rec.occurrences;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        if (w_accept) begin
            r_item <= t_item'(s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CODE_REGS; i++) begin
                r_codes[i] <= CODE_W'(i);
            end
        end else if (i_cfg_we && (i_cfg_idx < CODE_IDX_W'(CODE_REGS))) begin
            r_codes[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ----- hdl/frt_scan.sv -----
module frt_scan #(
    parameter int RECORD_SLOTS = frt_pkg::MAX_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_by_pos,
    input  logic [frt_pkg::CODE_W-1:0]    i_code,
    input  logic [frt_pkg::POS_W-1:0]     i_pos,
    input  frt_pkg::t_codes               i_codes,
    input  logic [RECORD_SLOTS-1:0]       i_active,
    output frt_pkg::t_scan_sts            o_sts,
    output logic [((RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1)-1:0] o_slot
);
    import frt_pkg::*;

    localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_SLOTS - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [POS_W-1:0] r_seen, n_seen;

    logic [CODE_W-1:0] w_cmp_a, w_cmp_b;
    logic              w_hit;
    logic              w_act;

    // one shared comparator: slot code vs. fault code, or active rank vs. position
    assign w_act   = i_active[r_idx];
    assign w_cmp_a = i_by_pos ? CODE_W'(r_seen) : i_codes[CODE_IDX_W'(r_idx)];
    assign w_cmp_b = i_by_pos ? CODE_W'(i_pos) : i_code;
    assign w_hit   = (w_cmp_a == w_cmp_b) && (!i_by_pos || w_act);

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_found = r_found;
        n_idx   = r_idx;
        n_seen  = r_seen;
        if (i_start) begin
            n_busy  = 1'b1;
            n_found = 1'b0;
            n_idx   = '0;
            n_seen  = '0;
        end else if (r_busy) begin
            if (w_hit || (r_idx == LAST_IDX)) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = w_hit;
            end else begin
                n_idx  = r_idx + 1'b1;
                n_seen = r_seen + POS_W'(w_act);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_seen  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_found <= n_found;
            r_idx   <= n_idx;
            r_seen  <= n_seen;
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.found = r_found;
    assign o_slot      = r_idx;

endmodule

// ----- hdl/frt_store.sv -----
module frt_store #(
    parameter int RECORD_SLOTS = frt_pkg::MAX_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  frt_pkg::t_store_wr         i_wr,
    input  logic [((RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1)-1:0] i_slot,
    input  logic [frt_pkg::DET_W-1:0]  i_detail,
    input  logic [frt_pkg::REV_W-1:0]  i_revision,
    input  logic [frt_pkg::EVT_W-1:0]  i_event,
    output frt_pkg::t_record           o_rec,
    output logic [RECORD_SLOTS-1:0]    o_active
);
    import frt_pkg::*;

    t_record r_rec [RECORD_SLOTS];
    t_record w_cur;
    t_record w_raised;

    assign w_cur = r_rec[i_slot];

    always_comb begin
        w_raised = w_cur;
        if (!w_cur.active) begin
            w_raised.first_det      = i_detail;
            w_raised.first_revision = i_revision;
            w_raised.first_event    = i_event;
            w_raised.occurrences    = OCC_W'(1);
        end else if (w_cur.occurrences != OCC_MAX) begin
            w_raised.occurrences = w_cur.occurrences + OCC_W'(1);
        end
        w_raised.last_det      = i_detail;
        w_raised.last_revision = i_revision;
        w_raised.last_event    = i_event;
        w_raised.active        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RECORD_SLOTS; s++) begin
                r_rec[s] <= '0;
            end
        end else if (i_wr.clear) begin
            r_rec[i_slot] <= '0;
        end else if (i_wr.raise) begin
            r_rec[i_slot] <= w_raised;
        end
    end

    always_comb begin
        for (int s = 0; s < RECORD_SLOTS; s++) begin
            o_active[s] = r_rec[s].active;
        end
    end

    assign o_rec = w_cur;

endmodule

// ----- hdl/frt_checker.sv -----
`include "assert_macros.svh"

module frt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [frt_pkg::OUT_W-1:0] m_axis_tdata
);
    import frt_pkg::*;

    t_result w_res;
    logic    w_stall;
    logic    w_in_acc;
    logic    w_total_ok;
    logic    w_miss;
    logic    w_rec_zero;

    assign w_res      = t_result'(m_axis_tdata);
    assign w_stall    = m_axis_tvalid && !m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_total_ok = (w_res.active_total <= TOTAL_W'(MAX_SLOTS));
    assign w_miss     = m_axis_tvalid && !w_res.ok;
    assign w_rec_zero = (w_res.rec_code == '0) && !w_res.rec_active &&
                        (w_res.rec_occurrences == '0) && (w_res.rec_last_event == '0);

    `CHK_ASSERT_ALWAYS(a_reset_no_valid, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

    `CHK_ASSERT(a_hold, i_clk, i_rst_n, w_stall |=> m_axis_tvalid && $stable(w_res), "result moved")

    `CHK_ASSERT(a_busy, i_clk, i_rst_n, w_in_acc |=> !s_axis_tready, "accepted while busy")

    `CHK_ASSERT(a_total_range, i_clk, i_rst_n, m_axis_tvalid |-> w_total_ok, "count out of range")

    `CHK_ASSERT(a_miss_zero, i_clk, i_rst_n, w_miss |-> w_rec_zero, "miss with record data")

endmodule

bind fault_record_table frt_checker u_frt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_fault_record_table.sv -----
`timescale 1ns / 100ps

module tb_fault_record_table;
    import frt_pkg::*;

    localparam int RUN_LIMIT   = 3_000_000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 290;
    localparam int BURST_ITEMS = 12;
    localparam int IDX_SPAN    = 1 << CODE_IDX_W;

    localparam logic [CODE_W-1:0] EDGE_CODES [CODE_REGS] =
        '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we;
    logic [CODE_IDX_W-1:0] i_cfg_idx;
    logic [CODE_W-1:0]     i_cfg_data;

    logic [CODE_W-1:0] slot_code [CODE_REGS];
    t_record           records [MAX_SLOTS];
    t_result           pending_reports [$];
    t_row              plan [$];

    int commands_sent = 0;
    int reports_seen  = 0;
    int mismatches    = 0;
    int settings_used = 1;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold       = 0;
    int cycle_count   = 0;

    fault_record_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void reset_table();
        for (int s = 0; s < CODE_REGS; s++) slot_code[s] = CODE_W'(s);
        for (int s = 0; s < MAX_SLOTS; s++) records[s] = '0;
    endfunction

    // Updates the record table for one command and returns its report.
    function automatic t_result apply_fault_cmd(input t_item it);
        t_result r;
        int hit;
        int seen;
        int total;
        r = '0;
        hit = -1;
        seen = 0;
        total = 0;
        if (it.cmd == CMD_READ_POS) begin
            for (int s = 0; s < MAX_SLOTS; s++) begin
                if (records[s].active) begin
                    if (hit < 0 && seen == int'(it.act_pos)) hit = s;
                    seen++;
                end
            end
        end else begin
            for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
                if (slot_code[s] == it.fault_code) hit = s;
            end
        end
        if (hit >= 0 && it.cmd == CMD_RAISE) begin
            if (!records[hit].active) begin
                records[hit].first_det      = it.detail;
                records[hit].first_revision = it.config_revision;
                records[hit].first_event    = it.evt_id;
                records[hit].occurrences    = '0;
            end
            records[hit].last_det      = it.detail;
            records[hit].last_revision = it.config_revision;
            records[hit].last_event    = it.evt_id;
            if (records[hit].occurrences != OCC_MAX) records[hit].occurrences++;
            records[hit].active = 1'b1;
        end else if (hit >= 0 && it.cmd == CMD_CLEAR) begin
            records[hit] = '0;
        end
        for (int s = 0; s < MAX_SLOTS; s++) total += records[s].active;
        r.active_total = total[TOTAL_W-1:0];
        if (hit >= 0) begin
            r.ok                 = 1'b1;
            r.rec_code           = slot_code[hit];
            r.rec_active         = records[hit].active;
            r.rec_first_det      = records[hit].first_det;
            r.rec_first_revision = records[hit].first_revision;
            r.rec_first_event    = records[hit].first_event;
            r.rec_last_det       = records[hit].last_det;
            r.rec_last_revision  = records[hit].last_revision;
            r.rec_last_event     = records[hit].last_event;
            r.rec_occurrences    = records[hit].occurrences;
        end
        return r;
    endfunction

    function automatic t_result report_of(
        input logic ok, input logic [TOTAL_W-1:0] total, input logic [CODE_W-1:0] code,
        input logic active, input logic [DET_W-1:0] fd, input logic [REV_W-1:0] fr,
        input logic [EVT_W-1:0] fe, input logic [DET_W-1:0] ld, input logic [REV_W-1:0] lr,
        input logic [EVT_W-1:0] le, input logic [OCC_W-1:0] occ);
        t_result r;
        r = '0;
        r.ok = ok;
        r.active_total = total;
        r.rec_code = code;
        r.rec_active = active;
        r.rec_first_det = fd;
        r.rec_first_revision = fr;
        r.rec_first_event = fe;
        r.rec_last_det = ld;
        r.rec_last_revision = lr;
        r.rec_last_event = le;
        r.rec_occurrences = occ;
        return r;
    endfunction

    function automatic void add_row(
        input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
        input logic [DET_W-1:0] det, input logic [REV_W-1:0] rev,
        input logic [EVT_W-1:0] evt, input logic [POS_W-1:0] pos,
        input bit typed, input t_result want);
        t_row row;
        row.item = '0;
        row.item.cmd = cmd;
        row.item.fault_code = code;
        row.item.detail = det;
        row.item.config_revision = rev;
        row.item.evt_id = evt;
        row.item.act_pos = pos;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic t_item random_cmd();
        t_item it;
        int pick;
        it = '0;
        pick = $urandom_range(99);
        it.cmd = (pick < 45) ? CMD_RAISE : (pick < 60) ? CMD_CLEAR :
                 (pick < 80) ? CMD_READ_CODE : CMD_READ_POS;
        if ($urandom_range(9) < 8)
            it.fault_code = slot_code[$urandom_range(CODE_REGS - 1)];
        else
            it.fault_code = CODE_W'($urandom);
        it.detail = DET_W'($urandom);
        it.config_revision = REV_W'($urandom);
        it.evt_id = $urandom;
        it.act_pos = POS_W'($urandom);
        return it;
    endfunction

    function automatic void cmp_field(input string name, input logic [EVT_W-1:0] want,
                                      input logic [EVT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic check_report(input t_result got);
        t_result want;
        reports_seen++;
        if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: report expected none actual %h", $time, got);
        end else begin
            want = pending_reports.pop_front();
            cmp_field("ok", want.ok, got.ok);
            cmp_field("active_total", want.active_total, got.active_total);
            cmp_field("rec_code", want.rec_code, got.rec_code);
            cmp_field("rec_active", want.rec_active, got.rec_active);
            cmp_field("rec_first_det", want.rec_first_det, got.rec_first_det);
            cmp_field("rec_first_revision", want.rec_first_revision, got.rec_first_revision);
            cmp_field("rec_first_event", want.rec_first_event, got.rec_first_event);
            cmp_field("rec_last_det", want.rec_last_det, got.rec_last_det);
            cmp_field("rec_last_revision", want.rec_last_revision, got.rec_last_revision);
            cmp_field("rec_last_event", want.rec_last_event, got.rec_last_event);
            cmp_field("rec_occurrences", want.rec_occurrences, got.rec_occurrences);
        end
    endtask

    // Issues one command, waits for the transaction, then maybe idles.
    task automatic send_cmd(input t_item it, input bit typed, input t_result want);
        t_result predicted;
        s_axis_tdata <= it;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_fault_cmd(it);
        pending_reports.push_back(typed ? want : predicted);
        commands_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Indexes past the slot list are written too; they must have no effect.
    task automatic program_codes(input int setting);
        logic [CODE_W-1:0] val;
        for (int s = 0; s < IDX_SPAN; s++) begin
            case (setting)
                1: val = (s < CODE_REGS) ? EDGE_CODES[s] : CODE_W'($urandom);
                2: val = 8'h00;
                3: val = CODE_W'($urandom_range(7));
                4: val = 8'hFF;
                default: val = CODE_W'($urandom);
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CODE_IDX_W'(s);
            i_cfg_data <= val;
            @(posedge i_clk);
            if (s < CODE_REGS) slot_code[s] = val;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) check_report(t_result'(m_axis_tdata));
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("%0t: run limit reached with %0d reports outstanding", $time,
                 pending_reports.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_item sat;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        reset_table();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, misses, positions past the end.
        add_row(CMD_READ_CODE, 8'hFF, 0, 0, 0, 0, 1,
                report_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_READ_POS, 0, 0, 0, 0, 0, 1,
                report_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CLEAR, 3, 0, 0, 0, 0, 1,
                report_of(1, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_RAISE, 0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 3'd7, 1,
                report_of(1, 1, 0, 1, 16'hFFFF, 0, 32'hFFFF_FFFF,
                          16'hFFFF, 0, 32'hFFFF_FFFF, 1));
        add_row(CMD_RAISE, 0, 16'h0000, 16'hFFFF, 32'h0000_0000, 0, 1,
                report_of(1, 1, 0, 1, 16'hFFFF, 0, 32'hFFFF_FFFF,
                          0, 16'hFFFF, 0, 2));
        add_row(CMD_RAISE, 5, 16'h1234, 16'h5678, 32'h9ABC_DEF0, 0, 1,
                report_of(1, 2, 5, 1, 16'h1234, 16'h5678, 32'h9ABC_DEF0,
                          16'h1234, 16'h5678, 32'h9ABC_DEF0, 1));
        add_row(CMD_READ_CODE, 5, 16'hAAAA, 16'h5555, 32'hA5A5_5A5A, 0, 0, '0);
        add_row(CMD_READ_POS, 0, 0, 0, 0, 1, 0, '0);
        add_row(CMD_READ_POS, 0, 0, 0, 0, 2, 1,
                report_of(0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_READ_POS, 0, 0, 0, 0, 7, 1,
                report_of(0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1,
                report_of(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1,
                report_of(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CLEAR, 8'hC8, 0, 0, 0, 0, 1,
                report_of(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_RAISE, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, 1,
                report_of(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_RAISE, 1, 16'h0001, 16'h8000, 32'h8000_0001, 0, 0, '0);
        add_row(CMD_RAISE, 2, 16'h7FFF, 16'h0001, 32'h7FFF_FFFE, 0, 0, '0);
        add_row(CMD_RAISE, 3, 16'hC3C3, 16'h3C3C, 32'h0F0F_F0F0, 0, 0, '0);
        add_row(CMD_RAISE, 4, 16'h0F0F, 16'hF0F0, 32'hF0F0_0F0F, 0, 0, '0);
        add_row(CMD_READ_POS, 0, 0, 0, 0, 4, 0, '0);
        add_row(CMD_READ_POS, 0, 0, 0, 0, 5, 1,
                report_of(0, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_RAISE, 1, 16'hBEEF, 16'hCAFE, 32'h1357_9BDF, 6, 0, '0);
        add_row(CMD_READ_CODE, 0, 0, 0, 0, 0, 1,
                report_of(1, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        tx_idle_pct = 13;
        rx_idle_pct = 74;
        foreach (plan[k]) send_cmd(plan[k].item, plan[k].typed, plan[k].want);
        drain_reports();

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 74 : 0;
            rx_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 13 : 0;
            if (ph > 0) program_codes(ph);
            // output held off while commands keep coming
            rx_hold = 200;
            repeat (BURST_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
            drain_reports();
            repeat (PHASE_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
            drain_reports();
        end

        // repeated raises on the lowest slot, then read, clear and raise again
        sat = random_cmd();
        sat.cmd = CMD_RAISE;
        sat.fault_code = slot_code[0];
        repeat (3) begin
            sat.detail = DET_W'($urandom);
            sat.evt_id = $urandom;
            send_cmd(sat, 1'b0, '0);
        end
        sat.cmd = CMD_READ_CODE;
        send_cmd(sat, 1'b0, '0);
        sat.cmd = CMD_CLEAR;
        send_cmd(sat, 1'b0, '0);
        sat.cmd = CMD_RAISE;
        send_cmd(sat, 1'b0, '0);
        drain_reports();
        repeat (12) @(posedge i_clk);

        $display("Run: %0d commands, %0d reports checked, %0d code settings,", commands_sent,
                 reports_seen, settings_used);
        $display("  with misses, duplicate codes, position reads and output back-pressure");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d field mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
